@@ src/edge_driven_shot_sequencer_macros.svh @@
// assertion helpers for the shot sequencer checker
`ifndef EDGE_DRIVEN_SHOT_SEQUENCER_MACROS_SVH
`define EDGE_DRIVEN_SHOT_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define ESQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/esq_pkg.sv @@
package esq_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_PULSE = 2'd2
  } phase_t;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_DAQ_DELAY      = 3'd0;
  localparam reg_idx_t REG_PULSE_WIDTH    = 3'd1;
  localparam reg_idx_t REG_CAMERA_EVERY   = 3'd2;
  localparam reg_idx_t REG_BASELINE_SHOTS = 3'd3;
  localparam reg_idx_t REG_RECORD_LENGTH  = 3'd4;
  localparam reg_idx_t REG_CYCLE_LENGTH   = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 80;
  localparam int unsigned TOTAL_W = 32;

  // line word: bit0 daq, bit1 camera, bit2 stimulus, bit3 block
  localparam logic [3:0] BLOCK_WORD = 4'b1000;
  localparam logic [2:0] MASK_DAQ   = 3'b001;
  localparam logic [2:0] MASK_CAM   = 3'b010;
  localparam logic [2:0] MASK_STIM  = 3'b100;

  typedef struct packed {
    logic [TOTAL_W-1:0] cycle_total;
    logic [TOTAL_W-1:0] shot_total;
    logic               busy;
    logic [3:0]         lamp;
    logic [3:0]         lines;
  } res_t;

endpackage

@@ src/esq_regs.sv @@
module esq_regs #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esq_pkg::ADDR_W-1:0]  paddr,
  input  logic [esq_pkg::DATA_W-1:0]  pwdata,
  output logic [esq_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [COUNT_WIDTH-1:0]      daq_delay,
  output logic [COUNT_WIDTH-1:0]      pulse_width,
  output logic [COUNT_WIDTH-1:0]      camera_every,
  output logic [COUNT_WIDTH-1:0]      baseline_shots,
  output logic [COUNT_WIDTH-1:0]      record_length,
  output logic [COUNT_WIDTH-1:0]      cycle_length
);

  esq_pkg::reg_idx_t idx;
  logic wr_en;
  logic [COUNT_WIDTH-1:0] wval;
  logic [COUNT_WIDTH-1:0] rval;

  assign pready = 1'b1;
  assign idx = paddr[esq_pkg::ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite & pready;
  assign wval = pwdata[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      daq_delay      <= '0;
      pulse_width    <= COUNT_WIDTH'(1);
      camera_every   <= COUNT_WIDTH'(1);
      baseline_shots <= '0;
      record_length  <= '1;
      cycle_length   <= '1;
    end else if (wr_en) begin
      unique case (idx)
        esq_pkg::REG_DAQ_DELAY:      daq_delay      <= wval;
        esq_pkg::REG_PULSE_WIDTH:    pulse_width    <= wval;
        esq_pkg::REG_CAMERA_EVERY:   camera_every   <= wval;
        esq_pkg::REG_BASELINE_SHOTS: baseline_shots <= wval;
        esq_pkg::REG_RECORD_LENGTH:  record_length  <= wval;
        esq_pkg::REG_CYCLE_LENGTH:   cycle_length   <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      esq_pkg::REG_DAQ_DELAY:      rval = daq_delay;
      esq_pkg::REG_PULSE_WIDTH:    rval = pulse_width;
      esq_pkg::REG_CAMERA_EVERY:   rval = camera_every;
      esq_pkg::REG_BASELINE_SHOTS: rval = baseline_shots;
      esq_pkg::REG_RECORD_LENGTH:  rval = record_length;
      esq_pkg::REG_CYCLE_LENGTH:   rval = cycle_length;
      default:                     rval = '0;
    endcase
  end

  assign prdata = esq_pkg::DATA_W'(rval);

endmodule

@@ src/esq_in_stage.sv @@
module esq_in_stage (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_level,
  output logic in_ready,
  input  logic take,
  output logic held_valid,
  output logic held_level
);

  // refills in the same cycle the held word is consumed
  assign in_ready = ~held_valid | take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_level <= in_level;
    end
  end

endmodule

@@ src/esq_core.sv @@
module esq_core #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   level,
  input  logic [COUNT_WIDTH-1:0] daq_delay,
  input  logic [COUNT_WIDTH-1:0] pulse_width,
  input  logic [COUNT_WIDTH-1:0] camera_every,
  input  logic [COUNT_WIDTH-1:0] baseline_shots,
  input  logic [COUNT_WIDTH-1:0] record_length,
  input  logic [COUNT_WIDTH-1:0] cycle_length,
  output esq_pkg::res_t          res
);

  logic                        last_level, last_level_next;
  esq_pkg::phase_t             phase, phase_next;
  logic [COUNT_WIDTH-1:0]      tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0]      shot_index, shot_index_next;
  logic [COUNT_WIDTH-1:0]      camera_phase, camera_phase_next;
  logic [2:0]                  shot_mask, shot_mask_next;
  logic [3:0]                  line_bits, line_bits_next;
  logic [3:0]                  lamp_latch, lamp_latch_next;
  logic [esq_pkg::TOTAL_W-1:0] shots_taken, shots_taken_next;
  logic [esq_pkg::TOTAL_W-1:0] cycles_done, cycles_done_next;

  logic                   rise;
  logic                   finish;
  logic [COUNT_WIDTH-1:0] every;
  logic [COUNT_WIDTH-1:0] idx_inc;
  logic [COUNT_WIDTH-1:0] cam_inc;

  assign rise    = level & ~last_level;
  assign every   = (camera_every == '0) ? COUNT_WIDTH'(1) : camera_every;
  assign idx_inc = shot_index + COUNT_WIDTH'(1);
  assign cam_inc = camera_phase + COUNT_WIDTH'(1);

  always_comb begin
    last_level_next   = level;
    phase_next        = phase;
    tick_count_next   = tick_count;
    shot_index_next   = shot_index;
    camera_phase_next = camera_phase;
    shot_mask_next    = shot_mask;
    line_bits_next    = line_bits;
    lamp_latch_next   = lamp_latch;
    shots_taken_next  = shots_taken;
    cycles_done_next  = cycles_done;
    finish            = 1'b0;

    unique case (phase)
      esq_pkg::PH_DELAY: begin
        if (tick_count >= daq_delay) begin
          if (shot_mask == 3'b000) begin
            // blocked shot: raise and hold the block line
            line_bits_next  = esq_pkg::BLOCK_WORD;
            lamp_latch_next = esq_pkg::BLOCK_WORD;
            finish          = 1'b1;
          end else begin
            lamp_latch_next = {1'b0, shot_mask};
            if (pulse_width == '0) begin
              line_bits_next = '0;
              finish         = 1'b1;
            end else begin
              line_bits_next  = {1'b0, shot_mask};
              tick_count_next = COUNT_WIDTH'(1);
              phase_next      = esq_pkg::PH_PULSE;
            end
          end
        end else begin
          tick_count_next = tick_count + COUNT_WIDTH'(1);
        end
      end
      esq_pkg::PH_PULSE: begin
        if (tick_count >= pulse_width) begin
          line_bits_next = '0;
          finish         = 1'b1;
        end else begin
          tick_count_next = tick_count + COUNT_WIDTH'(1);
        end
      end
      default: begin
        phase_next = esq_pkg::PH_IDLE;
        if (rise) begin
          if (shot_index >= record_length) begin
            shot_mask_next = 3'b000;
          end else begin
            shot_mask_next = esq_pkg::MASK_DAQ;
            if (camera_phase == '0) shot_mask_next = shot_mask_next | esq_pkg::MASK_CAM;
            if (shot_index == baseline_shots) begin
              shot_mask_next = shot_mask_next | esq_pkg::MASK_STIM;
            end
          end
          tick_count_next = '0;
          phase_next      = esq_pkg::PH_DELAY;
        end
      end
    endcase

    if (finish) begin
      shots_taken_next = shots_taken + esq_pkg::TOTAL_W'(1);
      if (shot_index == cycle_length) begin
        shot_index_next   = '0;
        camera_phase_next = '0;
        cycles_done_next  = cycles_done + esq_pkg::TOTAL_W'(1);
      end else begin
        shot_index_next = idx_inc;
        // index wrapped at its width: restart camera count, no cycle counted
        if (idx_inc == '0) begin
          camera_phase_next = '0;
        end else begin
          camera_phase_next = (cam_inc >= every) ? '0 : cam_inc;
        end
      end
      phase_next = esq_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      phase        <= esq_pkg::PH_IDLE;
      tick_count   <= '0;
      shot_index   <= '0;
      camera_phase <= '0;
      shot_mask    <= '0;
      line_bits    <= '0;
      lamp_latch   <= '0;
      shots_taken  <= '0;
      cycles_done  <= '0;
    end else if (step) begin
      last_level   <= last_level_next;
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      shot_index   <= shot_index_next;
      camera_phase <= camera_phase_next;
      shot_mask    <= shot_mask_next;
      line_bits    <= line_bits_next;
      lamp_latch   <= lamp_latch_next;
      shots_taken  <= shots_taken_next;
      cycles_done  <= cycles_done_next;
    end
  end

  always_comb begin
    res.lines       = line_bits_next;
    res.lamp        = lamp_latch_next;
    res.busy        = (phase_next != esq_pkg::PH_IDLE);
    res.shot_total  = shots_taken_next;
    res.cycle_total = cycles_done_next;
  end

endmodule

@@ src/esq_out_stage.sv @@
module esq_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  esq_pkg::res_t res_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output esq_pkg::res_t res_q
);

  assign free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

@@ src/edge_driven_shot_sequencer.sv @@
// a tick word accepted into the input register is taken once the result register is free
// throughput: one tick word per cycle; the input register and the result register
// decouple the two sides, so only a stalled result register holds back the input
// reset: synchronous, active high; counters, phase and lines clear, registers take
// their reset values; no clearing pass, the block accepts words right after reset
module edge_driven_shot_sequencer #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [esq_pkg::S_TDATA_W-1:0] s_tdata,  // [0] trigger_level, [7:1] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] daq_line, [1] camera_line, [2] stim_line, [3] block_line, [7:4] lamp_bits,
  // [8] busy_res, [40:9] shot_total, [72:41] cycle_total, [79:73] zero
  output logic [esq_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esq_pkg::ADDR_W-1:0]    paddr,
  input  logic [esq_pkg::DATA_W-1:0]    pwdata,
  output logic [esq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [COUNT_WIDTH-1:0] daq_delay, pulse_width, camera_every;
  logic [COUNT_WIDTH-1:0] baseline_shots, record_length, cycle_length;

  logic          held_valid, held_level;
  logic          out_free, step;
  esq_pkg::res_t res_next, res_q;

  assign step = held_valid & out_free;

  esq_regs #(.COUNT_WIDTH(COUNT_WIDTH)) u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .daq_delay      (daq_delay),
    .pulse_width    (pulse_width),
    .camera_every   (camera_every),
    .baseline_shots (baseline_shots),
    .record_length  (record_length),
    .cycle_length   (cycle_length)
  );

  esq_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_level   (s_tdata[0]),
    .in_ready   (s_tready),
    .take       (step),
    .held_valid (held_valid),
    .held_level (held_level)
  );

  esq_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .level          (held_level),
    .daq_delay      (daq_delay),
    .pulse_width    (pulse_width),
    .camera_every   (camera_every),
    .baseline_shots (baseline_shots),
    .record_length  (record_length),
    .cycle_length   (cycle_length),
    .res            (res_next)
  );

  esq_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .free      (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res_q     (res_q)
  );

  assign m_tdata = {7'b0000000, res_q.cycle_total, res_q.shot_total, res_q.busy,
                    res_q.lamp, res_q.lines};

endmodule

@@ src/esq_checker.sv @@
`include "edge_driven_shot_sequencer_macros.svh"

module esq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [esq_pkg::M_TDATA_W-1:0] m_tdata
);

  logic       stalled;
  logic [3:0] lines;
  logic       pulsing;
  logic       busy;

  assign stalled = m_tvalid & ~m_tready;
  assign lines   = m_tdata[3:0];
  assign pulsing = |lines[2:0];
  assign busy    = m_tdata[8];

  // a stalled result word holds
  `ESQ_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled word changed")

  // with the result register empty the input side must be open
  `ESQ_ASSERT_NOW(a_in_open, !m_tvalid, s_tready, "input closed with empty output")

  // block line never shares a word with a pulsing daq line
  `ESQ_ASSERT_NOW(a_block_excl, m_tvalid && lines[3], !pulsing, "block overlaps pulse")

  // camera or stimulus only pulse in a daq shot, and pulsing means busy
  `ESQ_ASSERT_NOW(a_pulse_busy, m_tvalid && pulsing, lines[0] && busy, "pulse not busy daq")

endmodule

bind edge_driven_shot_sequencer esq_checker u_esq_checker (.*);
